>>> sv/srb_pkg.sv
// Shared types and fixed constants of the sequence reorder buffer.
// No dependencies; used by srb_cell and sequence_reorder_buffer_core.
`default_nettype none

package srb_pkg;

    localparam int ID_W        = 64;
    localparam int HANDLE_W    = 16;
    localparam int LINK_W      = 3;
    localparam int TIMEOUT_W   = 16;
    localparam int LINKS       = 8;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(100);

    // Item codes
    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_TICK    = 1'b1;
    localparam logic KIND_DELIVERY = 1'b0;
    localparam logic KIND_BEYOND   = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [ID_W-1:0]     message_id;
        logic [LINK_W-1:0]   link_index;
        logic [HANDLE_W-1:0] payload_handle;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]     out_id;
        logic [HANDLE_W-1:0] out_handle;
        logic [LINK_W-1:0]   out_link;
        logic                out_kind;
        logic                out_last;
    } t_out_item;

    // Per-cycle command to the row of cells
    typedef struct packed {
        logic shift;   // every cell takes its upper neighbour's entry
        logic write;   // the selected cell stores the arrival if empty
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> sv/srb_cell.sv
// One window cell: valid bit, handle and link of the entry at its offset.
// Depends on srb_pkg (t_cell_ctrl, LINK_W).
`default_nettype none

module srb_cell #(
    parameter int HW = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire srb_pkg::t_cell_ctrl       i_ctrl,
    input  wire logic                      i_sel,
    input  wire logic [HW-1:0]             i_wr_handle,
    input  wire logic [srb_pkg::LINK_W-1:0] i_wr_link,
    input  wire logic                      i_nb_valid,
    input  wire logic [HW-1:0]             i_nb_handle,
    input  wire logic [srb_pkg::LINK_W-1:0] i_nb_link,
    output logic                           o_valid,
    output logic [HW-1:0]                  o_handle,
    output logic [srb_pkg::LINK_W-1:0]     o_link
);

    logic                       r_valid, n_valid;
    logic [HW-1:0]              r_handle, n_handle;
    logic [srb_pkg::LINK_W-1:0] r_link, n_link;
    logic                       store;

    // first copy wins: a duplicate never overwrites
    assign store = i_ctrl.write && i_sel && !r_valid;

    always_comb begin
        n_valid  = r_valid;
        n_handle = r_handle;
        n_link   = r_link;
        if (i_ctrl.shift) begin
            n_valid  = i_nb_valid;
            n_handle = i_nb_handle;
            n_link   = i_nb_link;
        end else if (store) begin
            n_valid  = 1'b1;
            n_handle = i_wr_handle;
            n_link   = i_wr_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_handle <= n_handle;
        r_link   <= n_link;
    end

    assign o_valid  = r_valid;
    assign o_handle = r_handle;
    assign o_link   = r_link;

endmodule

`default_nettype wire

>>> sv/sequence_reorder_buffer_core.sv
// Sequence reorder buffer top level: control sequencer over a row of srb_cell.
// Depends on srb_pkg and srb_cell.
`default_nettype none

// Restores id order for messages arriving over several links. An item is
// taken when start is high and busy is low; results come out at most one per
// cycle on o_result, marked by o_result_valid, and cannot be held off, so the
// receiver must take every strobed result. Cell k of the row holds the
// entry whose id is expected_id + k; delivering the head shifts the whole
// row down by one and bumps expected_id, so ordering needs no slot
// arithmetic. An arrival passes through the classify, drain and done
// states, a tick through the drain, timer and done states; when the gap
// timer fires, a tick also seeks past each empty offset in front of the
// lowest buffered id (at most WINDOW-1) and then makes a second drain
// pass. The row shifts one position per cycle in drain and seek.
// The last result of an item is on the ports in the first cycle with busy
// low. An arrival beyond the window gives one result with out_kind set,
// echoing its fields; stale ids, duplicates and bad links give none. The
// gap timeout register sits on its own valid/ready channel, always ready,
// and must only be written while idle.
module sequence_reorder_buffer_core #(
    parameter int WINDOW      = 32,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire srb_pkg::t_in_item              i_item,
    output logic                                o_result_valid,
    output srb_pkg::t_out_item                  o_result,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [srb_pkg::TIMEOUT_W-1:0]  i_cfg_data
);

    localparam int HW   = (HANDLE_BITS < srb_pkg::HANDLE_W) ? HANDLE_BITS
                                                            : srb_pkg::HANDLE_W;
    localparam int OFFW = $clog2(WINDOW);
    localparam int ID_W = srb_pkg::ID_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;  // classify arrival, store in row
    localparam logic [2:0] ST_DRAIN = 3'd2;  // deliver head while valid
    localparam logic [2:0] ST_TIMER = 3'd3;  // tick: advance gap timer
    localparam logic [2:0] ST_SEEK  = 3'd4;  // skip empty offsets after timeout
    localparam logic [2:0] ST_DONE  = 3'd5;  // timer upkeep, flush last result

    logic [2:0]                       r_state, n_state;
    srb_pkg::t_in_item                r_item, n_item;
    logic [ID_W-1:0]                  r_exp, n_exp;
    logic                             r_gap_active, n_gap_active;
    logic [srb_pkg::TIMEOUT_W-1:0]    r_gap_count, n_gap_count;
    logic [srb_pkg::TIMEOUT_W-1:0]    r_timeout, n_timeout;
    logic [srb_pkg::CNT_W-1:0]        r_cnt, n_cnt;
    logic                             r_skip, n_skip;
    logic                             r_pend_valid, n_pend_valid;
    srb_pkg::t_out_item               r_pend, n_pend;
    logic                             r_out_valid, n_out_valid;
    srb_pkg::t_out_item               r_out, n_out;

    // cell row
    srb_pkg::t_cell_ctrl              cell_ctrl;
    logic [WINDOW-1:0]                cell_valid;
    logic [HW-1:0]                    cell_handle [WINDOW];
    logic [srb_pkg::LINK_W-1:0]       cell_link [WINDOW];
    logic [WINDOW-1:0]                cell_sel;

    // arrival classification
    logic [ID_W:0]                    diff;
    logic                             id_ge;
    logic                             in_win;
    logic                             link_ok;
    logic [OFFW-1:0]                  off_lo;
    logic [HW-1:0]                    arr_handle;
    logic                             any_valid;
    logic                             can_emit;
    logic [srb_pkg::TIMEOUT_W-1:0]    cnt_inc;
    logic                             accept;

    // gathered result of this cycle
    logic                             gen_valid;
    srb_pkg::t_out_item               gen_item;

    assign accept     = start && !busy;
    assign busy       = (r_state != ST_IDLE);
    assign diff       = {1'b0, r_item.message_id} - {1'b0, r_exp};
    assign id_ge      = !diff[ID_W];
    assign in_win     = diff[ID_W-1:0] < ID_W'(WINDOW);
    assign link_ok    = int'(r_item.link_index) < srb_pkg::LINKS;
    assign off_lo     = diff[OFFW-1:0];
    assign arr_handle = r_item.payload_handle[HW-1:0];
    assign any_valid  = |cell_valid;
    assign can_emit   = cell_valid[0] && (r_cnt < srb_pkg::CNT_W'(srb_pkg::MAX_RESULTS));
    assign cnt_inc    = (r_gap_count == '1) ? r_gap_count : r_gap_count + 1'b1;

    genvar g;
    generate
        for (g = 0; g < WINDOW; g++) begin : g_cell
            assign cell_sel[g] = (off_lo == OFFW'(g));
            if (g == WINDOW - 1) begin : g_top
                srb_cell #(.HW(HW)) u_cell (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_ctrl      (cell_ctrl),
                    .i_sel       (cell_sel[g]),
                    .i_wr_handle (arr_handle),
                    .i_wr_link   (r_item.link_index),
                    .i_nb_valid  (1'b0),
                    .i_nb_handle ('0),
                    .i_nb_link   ('0),
                    .o_valid     (cell_valid[g]),
                    .o_handle    (cell_handle[g]),
                    .o_link      (cell_link[g])
                );
            end else begin : g_mid
                srb_cell #(.HW(HW)) u_cell (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_ctrl      (cell_ctrl),
                    .i_sel       (cell_sel[g]),
                    .i_wr_handle (arr_handle),
                    .i_wr_link   (r_item.link_index),
                    .i_nb_valid  (cell_valid[g+1]),
                    .i_nb_handle (cell_handle[g+1]),
                    .i_nb_link   (cell_link[g+1]),
                    .o_valid     (cell_valid[g]),
                    .o_handle    (cell_handle[g]),
                    .o_link      (cell_link[g])
                );
            end
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_exp        = r_exp;
        n_gap_active = r_gap_active;
        n_gap_count  = r_gap_count;
        n_timeout    = r_timeout;
        n_cnt        = r_cnt;
        n_skip       = r_skip;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = 1'b0;
        n_out        = r_out;
        cell_ctrl    = '0;
        gen_valid    = 1'b0;
        gen_item     = '0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_timeout = i_cfg_data;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_item  = i_item;
                    n_cnt   = '0;
                    n_skip  = 1'b0;
                    n_state = (i_item.cmd == srb_pkg::CMD_TICK) ? ST_DRAIN : ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (link_ok && id_ge) begin
                    if (!in_win) begin
                        gen_valid           = 1'b1;
                        gen_item.out_id     = r_item.message_id;
                        gen_item.out_handle = srb_pkg::HANDLE_W'(arr_handle);
                        gen_item.out_link   = r_item.link_index;
                        gen_item.out_kind   = srb_pkg::KIND_BEYOND;
                        n_cnt               = r_cnt + 1'b1;
                    end else begin
                        cell_ctrl.write = 1'b1;
                    end
                end
                n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (can_emit) begin
                    gen_valid           = 1'b1;
                    gen_item.out_id     = r_exp;
                    gen_item.out_handle = srb_pkg::HANDLE_W'(cell_handle[0]);
                    gen_item.out_link   = cell_link[0];
                    gen_item.out_kind   = srb_pkg::KIND_DELIVERY;
                    cell_ctrl.shift     = 1'b1;
                    n_exp               = r_exp + 1'b1;
                    n_cnt               = r_cnt + 1'b1;
                end else if (r_item.cmd == srb_pkg::CMD_TICK && !r_skip) begin
                    n_state = ST_TIMER;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_TIMER: begin
                n_state = ST_DONE;
                if (r_gap_active && any_valid) begin
                    n_gap_count = cnt_inc;
                    if (cnt_inc >= r_timeout) begin
                        n_gap_active = 1'b0;
                        n_gap_count  = '0;
                        n_skip       = 1'b1;
                        n_state      = ST_SEEK;
                    end
                end
            end
            ST_SEEK: begin
                // something is buffered, so the head turns valid within WINDOW-1 shifts
                if (cell_valid[0]) begin
                    n_state = ST_DRAIN;
                end else begin
                    cell_ctrl.shift = 1'b1;
                    n_exp           = r_exp + 1'b1;
                end
            end
            ST_DONE: begin
                if (!any_valid) begin
                    n_gap_active = 1'b0;
                    n_gap_count  = '0;
                end else if (!r_gap_active) begin
                    n_gap_active = 1'b1;
                    n_gap_count  = '0;
                end
                if (r_pend_valid) begin
                    n_out_valid       = 1'b1;
                    n_out             = r_pend;
                    n_out.out_last    = 1'b1;
                    n_pend_valid      = 1'b0;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // one result held back, so the final one can carry the last marker
        if (gen_valid) begin
            if (r_pend_valid) begin
                n_out_valid    = 1'b1;
                n_out          = r_pend;
                n_out.out_last = 1'b0;
            end
            n_pend_valid = 1'b1;
            n_pend       = gen_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_exp        <= '0;
            r_gap_active <= 1'b0;
            r_gap_count  <= '0;
            r_timeout    <= srb_pkg::TIMEOUT_RESET;
            r_cnt        <= '0;
            r_skip       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_exp        <= n_exp;
            r_gap_active <= n_gap_active;
            r_gap_count  <= n_gap_count;
            r_timeout    <= n_timeout;
            r_cnt        <= n_cnt;
            r_skip       <= n_skip;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;
    assign o_cfg_ready    = 1'b1;

    // ---- checks ----
    a_pend_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state != ST_IDLE))
        else $error("held result outside an item");

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= srb_pkg::CNT_W'(srb_pkg::MAX_RESULTS))
        else $error("result count beyond cap");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.out_last) |=> !o_result_valid)
        else $error("result straight after a last marker");

    a_seek_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEEK) |-> any_valid)
        else $error("seek with empty window");

    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without a start");

endmodule

`default_nettype wire

>>> dv/srb_order_checker.sv
// Order checker for the sequence reorder buffer: watches the item, result and
// timeout channels, predicts every result and compares it field by field.
// Depends on srb_pkg only.
module srb_order_checker #(
    parameter int WINDOW      = 32,
    parameter int HANDLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  srb_pkg::t_in_item             i_item,
    input  logic                          i_result_valid,
    input  srb_pkg::t_out_item            i_result,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [srb_pkg::TIMEOUT_W-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked,
    output logic [srb_pkg::ID_W-1:0]      o_next_id
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [srb_pkg::HANDLE_W-1:0] HANDLE_MASK =
        (HANDLE_BITS >= srb_pkg::HANDLE_W) ? '1
            : srb_pkg::HANDLE_W'((64'd1 << HANDLE_BITS) - 64'd1);

    // predicted block state
    logic                          held_valid  [WINDOW];
    logic [srb_pkg::HANDLE_W-1:0]  held_handle [WINDOW];
    logic [srb_pkg::LINK_W-1:0]    held_link   [WINDOW];
    logic [srb_pkg::ID_W-1:0]      next_expected;
    logic                          gap_on;
    logic [srb_pkg::TIMEOUT_W-1:0] gap_ticks;
    logic [srb_pkg::TIMEOUT_W-1:0] gap_limit;

    srb_pkg::t_out_item burst_q[$];     // results of the item being predicted
    srb_pkg::t_out_item due_results[$]; // predicted results not yet seen
    int                 fails     = 0;
    int                 checked_n = 0;

    function automatic int slot_of(input logic [srb_pkg::ID_W-1:0] id);
        return int'(id % 64'(WINDOW));
    endfunction

    function automatic bit any_held();
        for (int k = 0; k < WINDOW; k++)
            if (held_valid[k]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void emit(input logic [srb_pkg::ID_W-1:0] id,
                                 input logic [srb_pkg::HANDLE_W-1:0] h,
                                 input logic [srb_pkg::LINK_W-1:0] l, input logic kind);
        srb_pkg::t_out_item r;
        r.out_id     = id;
        r.out_handle = h;
        r.out_link   = l;
        r.out_kind   = kind;
        r.out_last   = 1'b0;
        burst_q      = {burst_q, r};
    endfunction

    // hand on consecutive ids from the head, capped per item
    function automatic void drain_run();
        int s;
        while (burst_q.size() < srb_pkg::MAX_RESULTS) begin
            s = slot_of(next_expected);
            if (!held_valid[s]) break;
            emit(next_expected, held_handle[s], held_link[s], srb_pkg::KIND_DELIVERY);
            held_valid[s] = 1'b0;
            next_expected = next_expected + 1'b1;
        end
    endfunction

    // distance to the lowest held id; WINDOW when nothing is reachable
    function automatic int lowest_gap();
        logic [srb_pkg::ID_W-1:0] room;
        room = '1 - next_expected;
        for (int k = 0; k < WINDOW; k++) begin
            if (64'(k) > room) break;
            if (held_valid[slot_of(next_expected + 64'(k))]) return k;
        end
        return WINDOW;
    endfunction

    function automatic void reorder_step(input srb_pkg::t_in_item it);
        logic [srb_pkg::ID_W-1:0]     off;
        logic [srb_pkg::HANDLE_W-1:0] h;
        int                           s;
        int                           k;
        burst_q.delete();
        if (it.cmd == srb_pkg::CMD_ARRIVAL) begin
            h = it.payload_handle & HANDLE_MASK;
            if (int'(it.link_index) < srb_pkg::LINKS && it.message_id >= next_expected) begin
                off = it.message_id - next_expected;
                if (off >= 64'(WINDOW)) begin
                    emit(it.message_id, h, it.link_index, srb_pkg::KIND_BEYOND);
                end else begin
                    s = slot_of(it.message_id);
                    if (!held_valid[s]) begin
                        held_valid[s]  = 1'b1;
                        held_handle[s] = h;
                        held_link[s]   = it.link_index;
                    end
                end
            end
            drain_run();
        end else begin
            drain_run();
            if (gap_on && any_held()) begin
                if (gap_ticks != '1) gap_ticks = gap_ticks + 1'b1;
                if (gap_ticks >= gap_limit) begin
                    k = lowest_gap();
                    if (k < WINDOW) next_expected = next_expected + 64'(k);
                    gap_on    = 1'b0;
                    gap_ticks = '0;
                    drain_run();
                end
            end
        end
        if (!any_held()) begin
            gap_on    = 1'b0;
            gap_ticks = '0;
        end else if (!gap_on) begin
            gap_on    = 1'b1;
            gap_ticks = '0;
        end
        if (burst_q.size() > 0) burst_q[$].out_last = 1'b1;
        due_results = {due_results, burst_q};
    endfunction

    task automatic report(input string what, input logic [srb_pkg::ID_W-1:0] got,
                          input logic [srb_pkg::ID_W-1:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
        fails++;
    endtask

    task automatic check_result(input srb_pkg::t_out_item got);
        srb_pkg::t_out_item want;
        if (due_results.size() == 0) begin
            report("unexpected result id", got.out_id, '0);
        end else begin
            want = due_results[0];
            due_results.delete(0);
            checked_n++;
            if (got.out_id !== want.out_id)
                report("out_id", got.out_id, want.out_id);
            if (got.out_handle !== want.out_handle)
                report("out_handle", 64'(got.out_handle), 64'(want.out_handle));
            if (got.out_link !== want.out_link)
                report("out_link", 64'(got.out_link), 64'(want.out_link));
            if (got.out_kind !== want.out_kind)
                report("out_kind", 64'(got.out_kind), 64'(want.out_kind));
            if (got.out_last !== want.out_last)
                report("out_last", 64'(got.out_last), 64'(want.out_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                held_valid[k]  = 1'b0;
                held_handle[k] = '0;
                held_link[k]   = '0;
            end
            next_expected = '0;
            gap_on        = 1'b0;
            gap_ticks     = '0;
            gap_limit     = srb_pkg::TIMEOUT_RESET;
            due_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) gap_limit = i_cfg_data;
            if (i_start && !i_busy) reorder_step(i_item);
            if (i_result_valid) check_result(i_result);
        end
        o_pending    <= due_results.size();
        o_next_id    <= next_expected;
        o_fail_count <= fails;
        o_checked    <= checked_n;
    end

endmodule

>>> dv/sequence_reorder_buffer_core_tb.sv
// Testbench top for sequence_reorder_buffer_core: clock, reset, stimulus and
// verdict; prediction and comparison live in srb_order_checker.
// Depends on srb_pkg, srb_order_checker and the block's RTL.
module sequence_reorder_buffer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW      = 32;
    localparam int HANDLE_BITS = 16;
    localparam int RAND_ITEMS  = 76;   // per random phase, five phases
    // Longest legal stretch with no handshake is a tick that fires the gap
    // timer and shifts the row past up to WINDOW-1 empty offsets, plus a
    // sender gap and the settle before a timeout write. This is many times that.
    localparam int QUIET_LIMIT = 2000;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          start       = 1'b0;
    logic                          busy;
    srb_pkg::t_in_item             item        = '0;
    logic                          result_valid;
    srb_pkg::t_out_item            result;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [srb_pkg::TIMEOUT_W-1:0] cfg_data    = '0;

    int                            fail_count;
    int                            pending;
    int                            checked;
    logic [srb_pkg::ID_W-1:0]      next_id;

    int                            items_sent  = 0;
    int                            ticks_sent  = 0;
    int                            quiet       = 0;

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    sequence_reorder_buffer_core #(
        .WINDOW      (WINDOW),
        .HANDLE_BITS (HANDLE_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (item),
        .o_result_valid (result_valid),
        .o_result       (result),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    srb_order_checker #(
        .WINDOW      (WINDOW),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_order_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (item),
        .i_result_valid (result_valid),
        .i_result       (result),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_next_id      (next_id)
    );

    // Watchdog: any item, result or register write resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet, pending);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Present one item and hold it until the block takes it. busy is read
    // straight after the edge, so it is the value the block saw at the edge.
    task automatic send(input srb_pkg::t_in_item it);
        item  <= it;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        items_sent++;
        if (it.cmd == srb_pkg::CMD_TICK) ticks_sent++;
    endtask

    // Random sender gap after roughly one item in ten; none when calm is set.
    task automatic pace(input bit calm);
        if (!calm && $urandom_range(0, 99) < 10) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic arrive(input logic [srb_pkg::ID_W-1:0] id,
                          input logic [srb_pkg::LINK_W-1:0] link,
                          input logic [srb_pkg::HANDLE_W-1:0] h);
        srb_pkg::t_in_item it;
        it.cmd            = srb_pkg::CMD_ARRIVAL;
        it.message_id     = id;
        it.link_index     = link;
        it.payload_handle = h;
        send(it);
        pace(1'b0);
    endtask

    // Tick fields are don't-care to the block, so they carry junk.
    task automatic tick(input logic [srb_pkg::ID_W-1:0] junk);
        srb_pkg::t_in_item it;
        it.cmd            = srb_pkg::CMD_TICK;
        it.message_id     = junk;
        it.link_index     = junk[srb_pkg::LINK_W-1:0];
        it.payload_handle = junk[srb_pkg::HANDLE_W-1:0];
        send(it);
        pace(1'b0);
    endtask

    // Wait for the block to go quiet: no item in flight and no result owed.
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (busy || pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [srb_pkg::TIMEOUT_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly ids just ahead of the expected one (in-order runs, holes,
    // duplicates), plus ticks, stale ids and arrivals past the window.
    // next_id may trail by an item or so, which only adds variety.
    function automatic srb_pkg::t_in_item make_item();
        srb_pkg::t_in_item it;
        int                pick;
        pick              = $urandom_range(0, 99);
        it.cmd            = srb_pkg::CMD_ARRIVAL;
        it.message_id     = {$urandom(), $urandom()};
        it.link_index     = srb_pkg::LINK_W'($urandom_range(0, srb_pkg::LINKS - 1));
        it.payload_handle = srb_pkg::HANDLE_W'($urandom_range(0, 65535));
        if (pick < 20)
            it.cmd = srb_pkg::CMD_TICK;
        else if (pick < 75)
            it.message_id = next_id + 64'($urandom_range(0, 10));
        else if (pick < 83)
            it.message_id = next_id + 64'($urandom_range(11, WINDOW - 1));
        else if (pick < 89)
            it.message_id = next_id + 64'($urandom_range(WINDOW, WINDOW + 8));
        else if (pick >= 94)
            it.message_id = next_id - 64'($urandom_range(1, 4));
        // else: fully random id, nearly always past the window
        return it;
    endfunction

    task automatic run_random(input int n, input bit calm);
        for (int i = 0; i < n; i++) begin
            send(make_item());
            pace(calm);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset timeout of 100: out-of-order pair, stale id,
        // duplicate keeping the first copy, last slot of the window, just
        // past the window and the all-ones id, ticks with all-ones and all-zero fields.
        arrive(64'd1, 3'd7, 16'hFFFF);
        arrive(64'd0, 3'd0, 16'h0000);
        arrive(64'd0, 3'd2, 16'h1111);
        arrive(64'd3, 3'd5, 16'h1234);
        arrive(64'd3, 3'd2, 16'h4321);
        arrive(64'd2, 3'd1, 16'hAAAA);
        arrive(64'd35, 3'd3, 16'h5555);
        arrive(64'd36, 3'd6, 16'h0F0F);
        arrive('1, 3'd7, 16'hFFFF);
        tick('1);
        tick('0);

        // Short timeout: the next tick skips the hole up to the held id.
        write_timeout(16'd2);
        tick(64'h5A5A_A5A5_0F0F_F0F0);
        arrive(64'd37, 3'd4, 16'h8000);
        arrive(64'd36, 3'd3, 16'h0001);

        // Random phases over the timeout range; the largest setting
        // runs with no sender gaps at all.
        write_timeout(16'd0);
        run_random(RAND_ITEMS, 1'b0);
        write_timeout(16'd1);
        run_random(RAND_ITEMS, 1'b0);
        write_timeout(16'hFFFF);
        run_random(RAND_ITEMS, 1'b1);
        write_timeout(16'($urandom_range(2, 8)));
        run_random(RAND_ITEMS, 1'b0);
        write_timeout(16'($urandom_range(9, 40)));
        run_random(RAND_ITEMS, 1'b0);

        settle();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d items (%0d ticks) and %0d checked results,", items_sent,
                 ticks_sent, checked);
        $display("with gap timeouts of 100, 2, 0, 1, 65535 and two random values.");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
sv/srb_pkg.sv
sv/srb_cell.sv
sv/sequence_reorder_buffer_core.sv
dv/srb_order_checker.sv
dv/sequence_reorder_buffer_core_tb.sv
